>>> src/uart_frame_buffer_with_gap_timeout_unit_defines.svh
// Assertion macros shared by the frame buffer RTL.
`ifndef UART_FRAME_BUFFER_WITH_GAP_TIMEOUT_UNIT_DEFINES_SVH
`define UART_FRAME_BUFFER_WITH_GAP_TIMEOUT_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_STEP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, expr, msg)
`define ASSERT_STEP(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> src/ufb_pkg.sv
// Types and constants for the serial frame buffer.
package ufb_pkg;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_RX_BYTE  = 3'd1;
  localparam logic [2:0] OP_TX_EMPTY = 3'd2;
  localparam logic [2:0] OP_SEND     = 3'd3;
  localparam logic [2:0] OP_BUF_WR   = 3'd4;
  localparam logic [2:0] OP_BUF_RD   = 3'd5;

  localparam logic [1:0] PAR_NONE = 2'd0;
  localparam logic [1:0] PAR_EVEN = 2'd1;
  localparam logic [1:0] PAR_INV  = 2'd2;

  localparam logic [1:0] REG_PARITY_MODE  = 2'd0;
  localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_GAP_TIMEOUT  = 2'd2;

  localparam logic [1:0] RST_PARITY_MODE  = PAR_EVEN;
  localparam logic [7:0] RST_IDLE_TIMEOUT = 8'd200;
  localparam logic [7:0] RST_GAP_TIMEOUT  = 8'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic [5:0] index;
    logic [6:0] send_length;
  } in_word_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_ninth;
    logic       frame_ready;
    logic [6:0] rx_length;
    logic [7:0] read_data;
    logic       rx_enabled;
  } out_word_t;

  typedef struct packed {
    logic [1:0] parity_mode;
    logic [7:0] idle_timeout;
    logic [7:0] gap_timeout;
  } cfg_t;

  typedef struct packed {
    logic       tx_valid;
    logic       frame_ready;
    logic       sw_read;
    logic [6:0] rx_length;
    logic       rx_enabled;
    logic [1:0] parity_mode;
  } meta_t;

endpackage

>>> src/uart_frame_buffer_with_gap_timeout_unit.sv
// Top level of the half-duplex serial frame buffer with gap timeout.
//
// Usage:
//   Input channel (item_valid / item_stall / item) carries one event word:
//   tick, received byte, transmitter empty, start send, buffer write or
//   buffer read. Every accepted word yields exactly one result word on the
//   result channel (result_valid / result_stall / result).
//   Each result passes through the buffer read register, then the result
//   register, after its word is accepted.
//   Throughput: one word per cycle while item_stall is low; the buffer has
//   one write and one registered read port, and each word uses at most one
//   of each. When the receiver stalls, the result register and the read
//   stage hold; item_stall rises only once both are full.
//   Reset (rst, synchronous) clears the counters, the written flags of the
//   buffer (unwritten entries read as zero) and loads the register
//   defaults. No clearing pass is needed. The user must write registers over
//   APB only while no word is in flight; the block does not enforce this.
module uart_frame_buffer_with_gap_timeout_unit #(
  parameter int BUF_LEN = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  ufb_pkg::in_word_t   item,
  output logic                result_valid,
  input  logic                result_stall,
  output ufb_pkg::out_word_t  result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = $clog2(BUF_LEN);
  localparam int CW = $clog2(BUF_LEN + 1);

  ufb_pkg::cfg_t  cfg;
  ufb_pkg::meta_t meta;
  logic           hold;
  logic           acc;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_data;

  assign item_stall = hold;
  assign acc        = item_valid && !hold;

  ufb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ufb_ctrl #(
    .BUF_LEN (BUF_LEN),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .item    (item),
    .cfg     (cfg),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .meta    (meta)
  );

  ufb_buf #(
    .BUF_LEN (BUF_LEN),
    .AW      (AW)
  ) u_buf (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ufb_out u_out (
    .clk          (clk),
    .rst          (rst),
    .acc          (acc),
    .meta         (meta),
    .rd_data      (rd_data),
    .hold         (hold),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> src/ufb_cfg.sv
// APB register block: parity mode, idle and gap timeouts.
module ufb_cfg (
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output ufb_pkg::cfg_t   cfg
);

  logic       wr;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.parity_mode  <= ufb_pkg::RST_PARITY_MODE;
      cfg.idle_timeout <= ufb_pkg::RST_IDLE_TIMEOUT;
      cfg.gap_timeout  <= ufb_pkg::RST_GAP_TIMEOUT;
    end else if (wr) begin
      case (reg_sel)
        ufb_pkg::REG_PARITY_MODE:  cfg.parity_mode  <= pwdata[1:0];
        ufb_pkg::REG_IDLE_TIMEOUT: cfg.idle_timeout <= pwdata[7:0];
        ufb_pkg::REG_GAP_TIMEOUT:  cfg.gap_timeout  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ufb_pkg::REG_PARITY_MODE:  prdata = {30'd0, cfg.parity_mode};
      ufb_pkg::REG_IDLE_TIMEOUT: prdata = {24'd0, cfg.idle_timeout};
      ufb_pkg::REG_GAP_TIMEOUT:  prdata = {24'd0, cfg.gap_timeout};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

>>> src/ufb_buf.sv
// Frame buffer memory with per-entry written flags; unwritten entries read as zero.
module ufb_buf #(
  parameter int BUF_LEN = 64,
  parameter int AW      = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0]         mem [BUF_LEN];
  logic [BUF_LEN-1:0] written;
  logic [7:0]         rd_raw;
  logic               rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_hit  <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit ? rd_raw : 8'd0;

endmodule

>>> src/ufb_ctrl.sv
// Frame control: gap counter, receive fill, send position and buffer access.
`include "uart_frame_buffer_with_gap_timeout_unit_defines.svh"
module ufb_ctrl #(
  parameter int BUF_LEN = 64,
  parameter int AW      = 6,
  parameter int CW      = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                acc,
  input  ufb_pkg::in_word_t   item,
  input  ufb_pkg::cfg_t       cfg,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  output ufb_pkg::meta_t      meta
);

  localparam int LW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] FILL_MAX = CW'(BUF_LEN);
  localparam logic [LW-1:0] LEN_MAX  = LW'(BUF_LEN);

  logic [7:0]    gap_counter, gap_counter_next;
  logic [CW-1:0] rx_fill, rx_fill_next;
  logic [CW-1:0] tx_total, tx_total_next;
  logic [CW-1:0] tx_position, tx_position_next;
  logic          receive_on, receive_on_next;
  logic [7:0]    station, station_next;

  logic [LW-1:0] idx_ext;
  logic [LW-1:0] len_ext;
  logic [LW-1:0] len_sat;
  logic          idx_ok;

  assign idx_ext = LW'(item.index);
  assign len_ext = LW'(item.send_length);
  assign len_sat = (len_ext > LEN_MAX) ? LEN_MAX : len_ext;
  assign idx_ok  = idx_ext < LEN_MAX;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_counter <= 8'd0;
      rx_fill     <= '0;
      tx_total    <= '0;
      tx_position <= '0;
      receive_on  <= 1'b0;
      station     <= 8'd0;
    end else if (acc) begin
      gap_counter <= gap_counter_next;
      rx_fill     <= rx_fill_next;
      tx_total    <= tx_total_next;
      tx_position <= tx_position_next;
      receive_on  <= receive_on_next;
      station     <= station_next;
    end
  end

  always_comb begin
    gap_counter_next = gap_counter;
    rx_fill_next     = rx_fill;
    tx_total_next    = tx_total;
    tx_position_next = tx_position;
    receive_on_next  = receive_on;
    station_next     = station;
    wr_en            = 1'b0;
    wr_addr          = rx_fill[AW-1:0];
    wr_data          = item.data;
    rd_en            = 1'b0;
    rd_addr          = tx_position[AW-1:0];
    meta             = '0;
    meta.parity_mode = cfg.parity_mode;

    case (item.op)
      ufb_pkg::OP_TICK: begin
        if ((rx_fill == '0 && gap_counter >= cfg.idle_timeout) ||
            (rx_fill != '0 && gap_counter >= cfg.gap_timeout)) begin
          meta.frame_ready = 1'b1;
          gap_counter_next = 8'd0;
        end else begin
          gap_counter_next = gap_counter + 8'd1;
        end
      end
      ufb_pkg::OP_RX_BYTE: begin
        gap_counter_next = 8'd0;
        if (rx_fill != '0 && rx_fill < FILL_MAX) begin
          wr_en        = acc;
          rx_fill_next = rx_fill + CW'(1);
        end else if (item.data == station) begin
          rx_fill_next = CW'(1);
        end else begin
          rx_fill_next = '0;
        end
      end
      ufb_pkg::OP_TX_EMPTY: begin
        gap_counter_next = 8'd0;
        if (tx_position < tx_total && tx_position < FILL_MAX) begin
          rd_en            = acc;
          meta.tx_valid    = 1'b1;
          tx_position_next = tx_position + CW'(1);
        end else begin
          tx_total_next   = '0;
          receive_on_next = 1'b1;
        end
      end
      ufb_pkg::OP_SEND: begin
        rx_fill_next  = '0;
        tx_total_next = CW'(len_sat);
        rd_addr       = '0;
        if (len_sat != '0) begin
          rd_en            = acc;
          meta.tx_valid    = 1'b1;
          tx_position_next = CW'(1);
        end
      end
      ufb_pkg::OP_BUF_WR: begin
        wr_addr = idx_ext[AW-1:0];
        if (idx_ok) begin
          wr_en = acc;
          if (idx_ext == '0) begin
            station_next = item.data;
          end
        end
      end
      ufb_pkg::OP_BUF_RD: begin
        rd_addr = idx_ext[AW-1:0];
        if (idx_ok) begin
          rd_en        = acc;
          meta.sw_read = 1'b1;
        end
      end
      default: ;
    endcase

    meta.rx_length  = 7'(rx_fill_next);
    meta.rx_enabled = receive_on_next;
  end

  `ASSERT_HOLDS(a_fill_max, clk, rst, rx_fill <= FILL_MAX, "rx fill above buffer length")
  `ASSERT_HOLDS(a_pos_max, clk, rst, tx_position <= FILL_MAX, "tx position above buffer length")
  `ASSERT_STEP(a_rx_sticky, clk, rst, receive_on, receive_on, "receive enable dropped")
  `ASSERT_STEP(a_gap_clear, clk, rst, acc && item.op == ufb_pkg::OP_RX_BYTE, gap_counter == 8'd0, "gap counter not cleared by byte")

endmodule

>>> src/ufb_out.sv
// Read stage and result register: merges buffer data, parity bit and status.
`include "uart_frame_buffer_with_gap_timeout_unit_defines.svh"
module ufb_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                acc,
  input  ufb_pkg::meta_t      meta,
  input  logic [7:0]          rd_data,
  output logic                hold,
  output logic                result_valid,
  input  logic                result_stall,
  output ufb_pkg::out_word_t  result
);

  logic               s1_valid;
  ufb_pkg::meta_t     s1_meta;
  logic               out_take;
  logic               parity;
  ufb_pkg::out_word_t built;

  assign out_take = !result_valid || !result_stall;
  assign hold     = s1_valid && !out_take;
  assign parity   = ^rd_data;

  always_comb begin
    built             = '0;
    built.tx_valid    = s1_meta.tx_valid;
    built.frame_ready = s1_meta.frame_ready;
    built.rx_length   = s1_meta.rx_length;
    built.rx_enabled  = s1_meta.rx_enabled;
    if (s1_meta.sw_read) begin
      built.read_data = rd_data;
    end
    if (s1_meta.tx_valid) begin
      built.tx_byte = rd_data;
      case (s1_meta.parity_mode)
        ufb_pkg::PAR_EVEN: built.tx_ninth = parity;
        ufb_pkg::PAR_INV:  built.tx_ninth = ~parity;
        default:           built.tx_ninth = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid <= acc || hold;
      if (out_take) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_meta <= meta;
    end
    if (out_take && s1_valid) begin
      result <= built;
    end
  end

  `ASSERT_STEP(a_s1_held, clk, rst, hold, s1_valid && result_valid, "read stage lost while stalled")
  `ASSERT_HOLDS(a_no_acc_hold, clk, rst, !(acc && hold), "word accepted into a held stage")

endmodule
